[hw/rtl/iheap_pkg.sv]
// Package with the controller state type and command codes of the indexed max-heap.
`default_nettype none
package iheap_pkg;

  // Command codes.
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // One-hot controller states.
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_INIT  = 14'b00000000000010,
    S_RD1   = 14'b00000000000100,
    S_UP    = 14'b00000000001000,
    S_UP1   = 14'b00000000010000,
    S_UP2   = 14'b00000000100000,
    S_DN    = 14'b00000001000000,
    S_DN1   = 14'b00000010000000,
    S_DN2   = 14'b00000100000000,
    S_DN3   = 14'b00001000000000,
    S_PLACE = 14'b00010000000000,
    S_TOP   = 14'b00100000000000,
    S_TOP1  = 14'b01000000000000,
    S_TOP2  = 14'b10000000000000
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/indexed_max_heap_core.sv]
// Indexed binary max-heap held in three memories with one registered read port each.
// Flow: a read fetches the entry's key and then looks up the root; a set writes the new key,
// walks up comparing with each parent or down comparing with the larger of each child
// pair, places the entry, then looks up the root; each memory gives one read per cycle.
// Throughput: one command at a time; the next is taken in the cycle that done is shown.
// Reset runs a clearing pass over all ENTRIES entries with busy high; done lasts one cycle.
`default_nettype none
module indexed_max_heap_core
  import iheap_pkg::*;
#(
  parameter int ENTRIES  = 1024,
  parameter int KEY_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [9:0]  entry,
  input  wire logic [31:0] new_key,
  output logic             done,
  output logic [31:0]      entry_key,
  output logic [9:0]       top_entry,
  output logic [31:0]      top_key
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = $clog2(ENTRIES + 1);
  localparam int CW = PW + 1;

  // Storage.
  logic [KEY_BITS-1:0] key_mem  [ENTRIES];
  logic [IW-1:0]       slot_mem [ENTRIES];
  logic [PW-1:0]       pos_mem  [ENTRIES];

  logic [KEY_BITS-1:0] key_rd;
  logic [IW-1:0]       slot_rd;
  logic [PW-1:0]       pos_rd;

  logic [IW-1:0]       key_raddr, slot_raddr, pos_raddr;
  logic                key_we, slot_we, pos_we;
  logic [IW-1:0]       key_waddr, slot_waddr, pos_waddr;
  logic [KEY_BITS-1:0] key_wdata;
  logic [IW-1:0]       slot_wdata;
  logic [PW-1:0]       pos_wdata;

  // Control and working registers.
  state_t              state, state_next;
  logic                cmd_q;
  logic [IW-1:0]       ent_q;
  logic [KEY_BITS-1:0] nk_q, ek_q, ek_next, lkey_q, lkey_next, tk_q;
  logic [PW-1:0]       p_q, p_next;
  logic [CW-1:0]       c_q, c_next;
  logic [IW-1:0]       le_q, le_next, re_q, re_next, pe_q, pe_next, te_q, te_next;
  logic                has_r_q, has_r_next;
  logic                done_next;
  logic [IW-1:0]       cnt;

  logic [CW-1:0]       child;
  logic [IW-1:0]       ce;
  logic [KEY_BITS-1:0] ck;
  logic [CW-1:0]       cp;

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    key_rd <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd <= pos_mem[pos_raddr];
  end

  // Sequencer: memory addresses, writes and next values.
  always_comb begin
    state_next = state;
    key_raddr  = ent_q;
    slot_raddr = '0;
    pos_raddr  = ent_q;
    key_we     = 1'b0;
    slot_we    = 1'b0;
    pos_we     = 1'b0;
    key_waddr  = ent_q;
    slot_waddr = '0;
    pos_waddr  = ent_q;
    key_wdata  = nk_q;
    slot_wdata = ent_q;
    pos_wdata  = p_q;
    ek_next    = ek_q;
    p_next     = p_q;
    c_next     = c_q;
    le_next    = le_q;
    re_next    = re_q;
    pe_next    = pe_q;
    te_next    = te_q;
    lkey_next  = lkey_q;
    has_r_next = has_r_q;
    done_next  = 1'b0;
    child      = {p_q, 1'b0};
    ce         = le_q;
    ck         = lkey_q;
    cp         = c_q;

    case (state)
      S_INIT: begin
        key_we     = 1'b1;
        slot_we    = 1'b1;
        pos_we     = 1'b1;
        key_waddr  = cnt;
        slot_waddr = cnt;
        pos_waddr  = cnt;
        key_wdata  = '0;
        slot_wdata = cnt;
        pos_wdata  = PW'({1'b0, cnt} + 1'b1);
        if (32'(cnt) == ENTRIES - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        key_raddr = IW'(entry);
        pos_raddr = IW'(entry);
        if (start) begin
          if (32'(entry) >= ENTRIES) begin
            ek_next    = '0;
            state_next = S_TOP;
          end else begin
            state_next = S_RD1;
          end
        end
      end
      S_RD1: begin
        if (cmd_q == CMD_READ) begin
          ek_next    = key_rd;
          state_next = S_TOP;
        end else begin
          key_we  = 1'b1;
          ek_next = nk_q;
          if (pos_rd == '0 || 32'(pos_rd) > ENTRIES) p_next = PW'(1);
          else p_next = pos_rd;
          state_next = (key_rd < nk_q) ? S_UP : S_DN;
        end
      end
      // Sift up: fetch parent entry, then its key, then compare.
      S_UP: begin
        slot_raddr = IW'((p_q >> 1) - 1'b1);
        state_next = (p_q == PW'(1)) ? S_PLACE : S_UP1;
      end
      S_UP1: begin
        pe_next    = slot_rd;
        key_raddr  = slot_rd;
        state_next = S_UP2;
      end
      S_UP2: begin
        if (key_rd < nk_q) begin
          slot_we    = 1'b1;
          slot_waddr = IW'(p_q - 1'b1);
          slot_wdata = pe_q;
          pos_we     = 1'b1;
          pos_waddr  = pe_q;
          pos_wdata  = p_q;
          p_next     = p_q >> 1;
          state_next = S_UP;
        end else begin
          state_next = S_PLACE;
        end
      end
      // Sift down: fetch both children and their keys, then compare.
      S_DN: begin
        c_next = child;
        if (32'(child) > ENTRIES) begin
          state_next = S_PLACE;
        end else begin
          slot_raddr = IW'(child - 1'b1);
          state_next = S_DN1;
        end
      end
      S_DN1: begin
        le_next    = slot_rd;
        key_raddr  = slot_rd;
        has_r_next = 32'(c_q) < ENTRIES;
        slot_raddr = (32'(c_q) < ENTRIES) ? IW'(c_q) : '0;
        state_next = S_DN2;
      end
      S_DN2: begin
        lkey_next  = key_rd;
        re_next    = slot_rd;
        key_raddr  = slot_rd;
        state_next = S_DN3;
      end
      S_DN3: begin
        if (has_r_q && (lkey_q < key_rd)) begin
          ce = re_q;
          ck = key_rd;
          cp = c_q + 1'b1;
        end
        if (nk_q < ck) begin
          slot_we    = 1'b1;
          slot_waddr = IW'(p_q - 1'b1);
          slot_wdata = ce;
          pos_we     = 1'b1;
          pos_waddr  = ce;
          pos_wdata  = p_q;
          p_next     = PW'(cp);
          state_next = S_DN;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        slot_we    = 1'b1;
        slot_waddr = IW'(p_q - 1'b1);
        slot_wdata = ent_q;
        pos_we     = 1'b1;
        pos_waddr  = ent_q;
        pos_wdata  = p_q;
        state_next = S_TOP;
      end
      // Root lookup for the result.
      S_TOP: begin
        slot_raddr = '0;
        state_next = S_TOP1;
      end
      S_TOP1: begin
        te_next    = slot_rd;
        key_raddr  = slot_rd;
        state_next = S_TOP2;
      end
      S_TOP2: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_INIT) cnt <= cnt + 1'b1;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q <= command;
      ent_q <= IW'(entry);
      nk_q  <= KEY_BITS'(new_key);
    end
    if (state == S_TOP2) tk_q <= key_rd;
    ek_q    <= ek_next;
    p_q     <= p_next;
    c_q     <= c_next;
    le_q    <= le_next;
    re_q    <= re_next;
    pe_q    <= pe_next;
    te_q    <= te_next;
    lkey_q  <= lkey_next;
    has_r_q <= has_r_next;
  end

  assign busy      = (state != S_IDLE);
  assign entry_key = 32'(ek_q);
  assign top_entry = 10'(te_q);
  assign top_key   = 32'(tk_q);

  // Checks.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted command did not raise busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while still busy");
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DN || state == S_UP || state == S_PLACE) |-> p_q != '0)
    else $error("heap position is zero during sift");
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |=> !done) else $error("result during clearing pass");

endmodule
`default_nettype wire
